// ===== src/adzc_pkg.sv =====
`timescale 1ns / 1ps
package adzc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int VAL_W = 12;
  localparam int DEN_W = 12;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam logic [VAL_W-1:0] OUT_MAX = 12'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_MIDPOINT  = 3'd0,
    REG_IN_MARGIN    = 3'd1,
    REG_DEAD_ZONE    = 3'd2,
    REG_OUT_MIDPOINT = 3'd3,
    REG_OUT_MARGIN   = 3'd4,
    REG_INVERT_MODE  = 3'd5
  } reg_idx_t;

  // Per-word control that rides alongside the divider lanes
  typedef struct packed {
    logic neg_a;
    logic neg_b;
    logic low;
    logic high;
    logic fault;
  } adzc_side_t;

endpackage

// ===== src/adzc_div.sv =====
`timescale 1ns / 1ps
module adzc_div #(
  parameter int MW = 28
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [MW-1:0]              in_num_a,
  input  logic [MW-1:0]              in_num_b,
  input  adzc_pkg::adzc_side_t       in_side,
  input  logic [adzc_pkg::DEN_W-1:0] den,
  output logic                       out_valid,
  output logic [MW-1:0]              out_q_a,
  output logic [MW-1:0]              out_q_b,
  output adzc_pkg::adzc_side_t       out_side
);
  import adzc_pkg::*;

  localparam int BPS = DIV_BITS_PER_STAGE;
  localparam int NST = (MW + BPS - 1) / BPS;

  // Restoring division, two lanes sharing one divisor, BPS quotient bits a stage
  logic [DEN_W-1:0] rem_a [NST+1];
  logic [DEN_W-1:0] rem_b [NST+1];
  logic [MW-1:0]    nq_a  [NST+1];
  logic [MW-1:0]    nq_b  [NST+1];
  logic             vld   [NST+1];
  adzc_side_t       side  [NST+1];

  assign rem_a[0] = '0;
  assign rem_b[0] = '0;
  assign nq_a[0]  = in_num_a;
  assign nq_b[0]  = in_num_b;
  assign vld[0]   = in_valid;
  assign side[0]  = in_side;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [DEN_W-1:0] ra_next, rb_next;
    logic [MW-1:0]    qa_next, qb_next;

    always_comb begin
      logic [DEN_W:0] ta, tb;
      ra_next = rem_a[k];
      rb_next = rem_b[k];
      qa_next = nq_a[k];
      qb_next = nq_b[k];
      for (int j = 0; j < BPS; j++) begin
        if (k * BPS + j < MW) begin
          ta = {ra_next, qa_next[MW-1]};
          tb = {rb_next, qb_next[MW-1]};
          qa_next = {qa_next[MW-2:0], 1'b0};
          qb_next = {qb_next[MW-2:0], 1'b0};
          if (ta >= {1'b0, den}) begin
            ta = ta - {1'b0, den};
            qa_next[0] = 1'b1;
          end
          if (tb >= {1'b0, den}) begin
            tb = tb - {1'b0, den};
            qb_next[0] = 1'b1;
          end
          ra_next = ta[DEN_W-1:0];
          rb_next = tb[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem_a[k+1] <= ra_next;
        rem_b[k+1] <= rb_next;
        nq_a[k+1]  <= qa_next;
        nq_b[k+1]  <= qb_next;
        side[k+1]  <= side[k];
      end
    end
  end

  assign out_valid = vld[NST];
  assign out_q_a   = nq_a[NST];
  assign out_q_b   = nq_b[NST];
  assign out_side  = side[NST];

endmodule

// ===== src/axis_deadzone_calibrator_core.sv =====
`timescale 1ns / 1ps
// Joystick axis calibrator: takes one raw ADC sample a cycle and returns the
// calibrated 12-bit axis value with a dead zone around the rest point and a
// linear gain outside it (all divisions truncate toward zero, result clipped
// to 0..4095). The pipelined restoring divider yields four quotient bits a
// stage. Throughput is one word a cycle while out_stall stays low; a stall
// freezes the whole pipeline and in_stall follows it in the same cycle. Write
// registers only when no word is in flight; cfg_ready is always high and
// writes to unknown indexes are dropped. divide_fault flags a non-positive
// in_margin minus twice dead_zone, and the value is then out_midpoint.
module axis_deadzone_calibrator_core #(
  parameter int SAMPLE_BITS = adzc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adzc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adzc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [adzc_pkg::VAL_W-1:0]      calibrated_value,
  output logic                            divide_fault
);
  import adzc_pkg::*;

  // Mirrored sample spans -(2^SAMPLE_BITS-1) .. max(8190, 2^SAMPLE_BITS-1), signed
  localparam int SW = ((SAMPLE_BITS > 13) ? SAMPLE_BITS : 13) + 2;
  localparam int PW = SW + 13;   // signed product width
  localparam int MW = PW;        // divider magnitude width
  localparam int VW = MW + 3;    // sum width

  // Configuration registers
  logic [11:0] in_midpoint, in_margin, out_midpoint, out_margin;
  logic [10:0] dead_zone;
  logic [1:0]  invert_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_midpoint  <= 12'd2048;
      in_margin    <= 12'd2048;
      dead_zone    <= 11'd0;
      out_midpoint <= 12'd2048;
      out_margin   <= 12'd2048;
      invert_mode  <= 2'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IN_MIDPOINT:  in_midpoint  <= cfg_data;
        REG_IN_MARGIN:    in_margin    <= cfg_data;
        REG_DEAD_ZONE:    dead_zone    <= cfg_data[10:0];
        REG_OUT_MIDPOINT: out_midpoint <= cfg_data;
        REG_OUT_MARGIN:   out_margin   <= cfg_data;
        REG_INVERT_MODE:  invert_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together; it holds only when the output word waits
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Divisor: in_margin - 2*dead_zone, fault when not positive
  logic signed [13:0] den_c;
  logic               fault_c;
  assign den_c   = $signed({2'b00, in_margin}) - $signed({2'b00, dead_zone, 1'b0});
  assign fault_c = (den_c <= 14'sd0);

  // Stage A: mirror input, pick side and offset numerator
  logic signed [SW-1:0] imid_s, dz_s, smp_s, s_c, x_c, marg_s;
  logic                 low_c, high_c;

  assign imid_s = $signed({{(SW-12){1'b0}}, in_midpoint});
  assign dz_s   = $signed({{(SW-12){1'b0}}, dead_zone, 1'b0});
  assign marg_s = $signed({{(SW-12){1'b0}}, in_margin});
  assign smp_s  = $signed({{(SW-SAMPLE_BITS){1'b0}}, sample});
  assign s_c    = invert_mode[0] ? (imid_s + imid_s - smp_s) : smp_s;
  assign low_c  = s_c < (imid_s - dz_s);
  assign high_c = s_c > (imid_s + dz_s);
  assign x_c    = low_c ? (marg_s - imid_s) : (-dz_s - imid_s);

  logic                 a_valid, a_low, a_high, a_fault;
  logic signed [SW-1:0] a_s, a_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_s     <= s_c;
      a_x     <= x_c;
      a_low   <= low_c;
      a_high  <= high_c;
      a_fault <= fault_c;
    end
  end

  // Stage B: gain products
  logic signed [12:0]   omarg_s;
  logic signed [PW-1:0] p1_c, p2_c;
  assign omarg_s = $signed({1'b0, out_margin});
  assign p1_c    = PW'(a_s) * PW'(omarg_s);
  assign p2_c    = PW'(a_x) * PW'(omarg_s);

  logic                 b_valid, b_low, b_high, b_fault;
  logic signed [PW-1:0] b_p1, b_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_p1    <= p1_c;
      b_p2    <= p2_c;
      b_low   <= a_low;
      b_high  <= a_high;
      b_fault <= a_fault;
    end
  end

  // Stage C: split into sign and magnitude for the divider
  logic             c_valid;
  logic [MW-1:0]    c_mag1, c_mag2;
  adzc_side_t       c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
    if (adv) begin
      c_mag1       <= b_p1[PW-1] ? MW'(-b_p1) : MW'(b_p1);
      c_mag2       <= b_p2[PW-1] ? MW'(-b_p2) : MW'(b_p2);
      c_side.neg_a <= b_p1[PW-1];
      c_side.neg_b <= b_p2[PW-1];
      c_side.low   <= b_low;
      c_side.high  <= b_high;
      c_side.fault <= b_fault;
    end
  end

  // Divider stages
  logic          d_valid;
  logic [MW-1:0] d_q1, d_q2;
  adzc_side_t    d_side;

  adzc_div #(
    .MW (MW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (c_valid),
    .in_num_a  (c_mag1),
    .in_num_b  (c_mag2),
    .in_side   (c_side),
    .den       (den_c[11:0]),
    .out_valid (d_valid),
    .out_q_a   (d_q1),
    .out_q_b   (d_q2),
    .out_side  (d_side)
  );

  // Stage E: restore signs, add offsets
  logic signed [VW-1:0] q1_s, q2_s, omid_v, omarg_v, sum_c, v_c;
  assign q1_s    = d_side.neg_a ? -$signed({3'b000, d_q1}) : $signed({3'b000, d_q1});
  assign q2_s    = d_side.neg_b ? -$signed({3'b000, d_q2}) : $signed({3'b000, d_q2});
  assign omid_v  = $signed({{(VW-12){1'b0}}, out_midpoint});
  assign omarg_v = $signed({{(VW-12){1'b0}}, out_margin});
  assign sum_c   = q1_s + q2_s + omid_v - (d_side.low ? omarg_v : '0);
  assign v_c     = (d_side.low || d_side.high) ? sum_c : omid_v;

  logic                 e_valid, e_fault;
  logic signed [VW-1:0] e_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
    if (adv) begin
      e_v     <= v_c;
      e_fault <= d_side.fault;
    end
  end

  // Stage F: mirror output, saturate, fault override
  logic signed [VW-1:0] vm_c;
  logic [VAL_W-1:0]     sat_c;
  assign vm_c = invert_mode[1] ? (omid_v + omid_v - e_v) : e_v;

  always_comb begin
    if (vm_c < 0) begin
      sat_c = '0;
    end else if (vm_c > $signed({{(VW-12){1'b0}}, OUT_MAX})) begin
      sat_c = OUT_MAX;
    end else begin
      sat_c = vm_c[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= e_valid;
    end
    if (adv) begin
      calibrated_value <= e_fault ? out_midpoint : sat_c;
      divide_fault     <= e_fault;
    end
  end

endmodule
